@@ rtl/sfcs_pkg.sv @@
`timescale 1ns / 1ps
// shared types, opcodes and sizes for the spi nor flash command sequencer
// no dependencies
package sfcs_pkg;

    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_LOG     = $clog2(PAGE_BYTES);
    localparam int CHUNK_W      = $clog2(PAGE_BYTES + 1);
    localparam int MAX_BEATS    = 6;
    localparam int CNT_W        = $clog2(MAX_BEATS + 1);

    // request codes
    localparam logic [2:0] CMD_RD_REQ = 3'd0;
    localparam logic [2:0] CMD_ERASE  = 3'd1;
    localparam logic [2:0] CMD_PROG   = 3'd2;
    localparam logic [2:0] CMD_DATA   = 3'd3;
    localparam logic [2:0] CMD_STATUS = 3'd4;

    // sequencer modes, code 3 behaves as idle
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ERASE = 2'd1;
    localparam logic [1:0] MODE_PROG  = 2'd2;

    // flash opcodes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR1 = 8'h05;
    localparam logic [7:0] OP_SE4K  = 8'h20;
    localparam logic [7:0] OP_READ  = 8'h03;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [23:0] address;
        logic [24:0] length;
        logic [7:0]  data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic        poll;
        logic [24:0] rx_count;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]         mode;
        logic [23:0]        cur_address;
        logic [24:0]        remaining;
        logic [CHUNK_W-1:0] chunk_left;
        logic               awaiting_status;
    } t_state;

    typedef struct packed {
        t_out_beat [MAX_BEATS-1:0] beat;
        logic [CNT_W-1:0]          count;
    } t_burst;

endpackage

@@ rtl/sfcs_step.sv @@
`timescale 1ns / 1ps
// next-state and result-burst logic for one input beat
// depends on sfcs_pkg
module sfcs_step (
    input  sfcs_pkg::t_state   i_state,
    input  sfcs_pkg::t_in_beat i_item,
    output sfcs_pkg::t_state   o_state,
    output sfcs_pkg::t_burst   o_burst
);
    import sfcs_pkg::*;

    function automatic t_out_beat mk(input logic [7:0] b, input logic fe, input logic pl,
                                     input logic [24:0] rx);
        t_out_beat r;
        r.out_byte  = b;
        r.frame_end = fe;
        r.poll      = pl;
        r.rx_count  = rx;
        r.last      = 1'b0;
        return r;
    endfunction

    // bytes left in the page from addr, capped by the remaining count
    function automatic logic [CHUNK_W-1:0] chunk_of(input logic [23:0] a,
                                                    input logic [24:0] rem);
        logic [CHUNK_W-1:0] room;
        room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(a[PAGE_LOG-1:0]);
        if (25'(room) > rem) begin
            return rem[CHUNK_W-1:0];
        end
        return room;
    endfunction

    logic               idle;
    logic [CHUNK_W-1:0] chunk_dec;
    logic [24:0]        erase_step;
    logic [24:0]        erase_rem;
    logic [23:0]        erase_addr;
    t_burst             burst;

    assign idle       = (i_state.mode != MODE_ERASE) && (i_state.mode != MODE_PROG);
    assign chunk_dec  = i_state.chunk_left - CHUNK_W'(1);
    assign erase_step = (i_state.remaining > 25'(SECTOR_BYTES)) ? 25'(SECTOR_BYTES)
                                                                : i_state.remaining;
    assign erase_rem  = i_state.remaining - erase_step;
    assign erase_addr = i_state.cur_address + 24'(SECTOR_BYTES);

    always_comb begin
        o_state = i_state;
        burst   = '0;
        priority if (i_item.cmd == CMD_RD_REQ && idle) begin
            burst.beat[0] = mk(OP_WRDI, 1'b1, 1'b0, '0);
            burst.beat[1] = mk(OP_READ, 1'b0, 1'b0, '0);
            burst.beat[2] = mk(i_item.address[23:16], 1'b0, 1'b0, '0);
            burst.beat[3] = mk(i_item.address[15:8], 1'b0, 1'b0, '0);
            burst.beat[4] = mk(i_item.address[7:0], 1'b1, 1'b0, i_item.length);
            burst.count   = CNT_W'(5);
        end else if (i_item.cmd == CMD_ERASE && idle && i_item.length != '0) begin
            o_state.mode            = MODE_ERASE;
            o_state.cur_address     = i_item.address;
            o_state.remaining       = i_item.length;
            o_state.awaiting_status = 1'b1;
            burst.beat[0] = mk(OP_WREN, 1'b1, 1'b0, '0);
            burst.beat[1] = mk(OP_SE4K, 1'b0, 1'b0, '0);
            burst.beat[2] = mk(i_item.address[23:16], 1'b0, 1'b0, '0);
            burst.beat[3] = mk(i_item.address[15:8], 1'b0, 1'b0, '0);
            burst.beat[4] = mk(i_item.address[7:0], 1'b1, 1'b0, '0);
            burst.beat[5] = mk(OP_RDSR1, 1'b1, 1'b1, '0);
            burst.count   = CNT_W'(6);
        end else if (i_item.cmd == CMD_PROG && idle && i_item.length != '0) begin
            o_state.mode            = MODE_PROG;
            o_state.cur_address     = i_item.address;
            o_state.remaining       = i_item.length;
            o_state.awaiting_status = 1'b0;
            o_state.chunk_left      = chunk_of(i_item.address, i_item.length);
            burst.beat[0] = mk(OP_WREN, 1'b1, 1'b0, '0);
            burst.beat[1] = mk(OP_PP, 1'b0, 1'b0, '0);
            burst.beat[2] = mk(i_item.address[23:16], 1'b0, 1'b0, '0);
            burst.beat[3] = mk(i_item.address[15:8], 1'b0, 1'b0, '0);
            burst.beat[4] = mk(i_item.address[7:0], 1'b0, 1'b0, '0);
            burst.count   = CNT_W'(5);
        end else if (i_item.cmd == CMD_DATA && i_state.mode == MODE_PROG
                     && !i_state.awaiting_status && i_state.chunk_left != '0) begin
            o_state.chunk_left  = chunk_dec;
            o_state.remaining   = i_state.remaining - 25'd1;
            o_state.cur_address = i_state.cur_address + 24'd1;
            if (chunk_dec == '0) begin
                o_state.awaiting_status = 1'b1;
                burst.beat[0] = mk(i_item.data_byte, 1'b1, 1'b0, '0);
                burst.beat[1] = mk(OP_RDSR1, 1'b1, 1'b1, '0);
                burst.count   = CNT_W'(2);
            end else begin
                burst.beat[0] = mk(i_item.data_byte, 1'b0, 1'b0, '0);
                burst.count   = CNT_W'(1);
            end
        end else if (i_item.cmd == CMD_STATUS && i_state.mode == MODE_ERASE
                     && !i_state.awaiting_status) begin
            // first poll of a sector whose erase frame went out on the last reply
            o_state.awaiting_status = 1'b1;
            burst.beat[0] = mk(OP_RDSR1, 1'b1, 1'b1, '0);
            burst.count   = CNT_W'(1);
        end else if (i_item.cmd == CMD_STATUS && i_state.awaiting_status && !idle) begin
            if (i_item.data_byte[0]) begin
                burst.beat[0] = mk(OP_RDSR1, 1'b1, 1'b1, '0);
                burst.count   = CNT_W'(1);
            end else begin
                o_state.awaiting_status = 1'b0;
                burst.beat[0] = mk(OP_WRDI, 1'b1, 1'b0, '0);
                burst.count   = CNT_W'(1);
                if (i_state.mode == MODE_ERASE) begin
                    o_state.remaining   = erase_rem;
                    o_state.cur_address = erase_addr;
                    if (erase_rem != '0) begin
                        burst.beat[1] = mk(OP_WREN, 1'b1, 1'b0, '0);
                        burst.beat[2] = mk(OP_SE4K, 1'b0, 1'b0, '0);
                        burst.beat[3] = mk(erase_addr[23:16], 1'b0, 1'b0, '0);
                        burst.beat[4] = mk(erase_addr[15:8], 1'b0, 1'b0, '0);
                        burst.beat[5] = mk(erase_addr[7:0], 1'b1, 1'b0, '0);
                        burst.count   = CNT_W'(6);
                    end else begin
                        o_state.mode = MODE_IDLE;
                    end
                end else begin
                    if (i_state.remaining != '0) begin
                        o_state.chunk_left = chunk_of(i_state.cur_address, i_state.remaining);
                        burst.beat[1] = mk(OP_WREN, 1'b1, 1'b0, '0);
                        burst.beat[2] = mk(OP_PP, 1'b0, 1'b0, '0);
                        burst.beat[3] = mk(i_state.cur_address[23:16], 1'b0, 1'b0, '0);
                        burst.beat[4] = mk(i_state.cur_address[15:8], 1'b0, 1'b0, '0);
                        burst.beat[5] = mk(i_state.cur_address[7:0], 1'b0, 1'b0, '0);
                        burst.count   = CNT_W'(6);
                    end else begin
                        o_state.mode = MODE_IDLE;
                    end
                end
            end
        end else begin
            burst.count = '0;
        end
    end

    // flag the final beat of the burst
    always_comb begin
        o_burst = burst;
        for (int i = 0; i < MAX_BEATS; i++) begin
            o_burst.beat[i].last = (burst.count != '0)
                                   && (CNT_W'(i) == burst.count - CNT_W'(1));
        end
    end

endmodule

@@ rtl/spi_nor_flash_command_sequencer_top.sv @@
`timescale 1ns / 1ps
// top level of the spi nor flash command sequencer: state, burst buffer, handshakes
// depends on sfcs_pkg and sfcs_step
//
//  channel   direction  signals                          payload
//  in        input      i_in_valid / o_in_ready          sfcs_pkg::t_in_beat
//  out       output     o_out_valid / i_out_ready        sfcs_pkg::t_out_beat
//
// an accepted beat is decoded in the cycle it arrives: the sequencer state is
// updated and its burst of zero to six result beats lands in the burst buffer
// the buffer drains one beat per cycle while the output is ready, so an item
// holds the block until its result beats have left the single output port
// the next input beat is taken in the cycle the last result beat leaves
// synchronous active-low reset empties the buffer and returns the mode to idle
// a stalled output simply holds the current beat and blocks the input
module spi_nor_flash_command_sequencer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sfcs_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sfcs_pkg::t_out_beat o_out_data
);
    import sfcs_pkg::*;

    // sequencer state: mode, address, byte counts, poll flag
    t_state           r_state;
    t_state           n_state;
    // decoded results waiting to go out, and the read pointer into them
    t_burst           r_buf;
    t_burst           n_buf;
    logic [CNT_W-1:0] r_rd;

    logic in_take;
    logic out_take;
    logic on_last;

    sfcs_step u_step (
        .i_state (r_state),
        .i_item  (i_in_data),
        .o_state (n_state),
        .o_burst (n_buf)
    );

    assign o_out_valid = (r_rd != r_buf.count);
    assign on_last     = (r_rd == r_buf.count - CNT_W'(1));
    // input opens when the buffer is empty or its final beat is leaving now
    assign o_in_ready  = !o_out_valid || (on_last && i_out_ready);
    assign in_take     = i_in_valid && o_in_ready;
    assign out_take    = o_out_valid && i_out_ready;
    assign o_out_data  = r_buf.beat[r_rd[CNT_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_buf   <= '0;
            r_rd    <= '0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
                r_buf   <= n_buf;
                r_rd    <= '0;
            end else if (out_take) begin
                r_rd <= r_rd + CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/sfcs_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the command sequencer, bound to the top level
// depends on sfcs_pkg and spi_nor_flash_command_sequencer_top
module sfcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input sfcs_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input sfcs_pkg::t_out_beat o_out_data
);
    import sfcs_pkg::*;

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // no input taken while a burst is still mid-way
    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input accepted in the middle of a burst");

    // a poll beat is always a lone rdsr1 frame
    a_poll_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.poll |->
            o_out_data.frame_end && o_out_data.out_byte == OP_RDSR1 && o_out_data.last)
        else $error("poll beat is not a closed status read");

    // receive count only on the closing byte of a frame
    a_rx_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rx_count != '0 |-> o_out_data.frame_end)
        else $error("receive count outside a frame end");

endmodule

bind spi_nor_flash_command_sequencer_top sfcs_checker u_sfcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ test/tb_spi_nor_flash_command_sequencer_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for spi_nor_flash_command_sequencer_top: predicts the spi beats of
// every accepted request, data byte and status reply and compares them in order
// depends on sfcs_pkg and the sequencer rtl
module tb_spi_nor_flash_command_sequencer_top;
    import sfcs_pkg::*;

    // command codes the block does not decode
    localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
    // write-in-progress bit of the status register
    localparam logic [7:0] SR_BUSY        = 8'h01;

    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 70;    // random part, on top of the directed beats
    localparam int CALM_TAIL     = 20;    // final beats sent with no idling
    localparam int REPORT_MAX    = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    // pending input beats, expected spi beats, and the burst built for one input beat
    t_in_beat  requests_pending[$];
    t_out_beat spi_bytes_due[$];
    t_out_beat burst_q[$];

    // shadow copy of the sequencer state
    logic [1:0]         seq_mode       = MODE_IDLE;
    logic [23:0]        seq_addr       = '0;
    logic [24:0]        seq_remaining  = '0;
    logic [CHUNK_W-1:0] seq_chunk_left = '0;
    logic               seq_wait_sr    = 1'b0;

    logic in_took       = 1'b0;
    logic random_loaded = 1'b0;
    int   in_gap        = 0;
    int   out_stall     = 0;
    int   quiet_cycles  = 0;
    int   fail_count    = 0;

    spi_nor_flash_command_sequencer_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void emit(input logic [7:0] b, input logic fe, input logic pl,
                                 input logic [24:0] rx);
        t_out_beat r;
        r.out_byte  = b;
        r.frame_end = fe;
        r.poll      = pl;
        r.rx_count  = rx;
        r.last      = 1'b0;
        burst_q.push_back(r);
    endfunction

    // three address bytes, msb first; chip select may drop after the low byte
    function automatic void emit_address(input logic [23:0] a, input logic fe_last);
        emit(a[23:16], 1'b0, 1'b0, '0);
        emit(a[15:8], 1'b0, 1'b0, '0);
        emit(a[7:0], fe_last, 1'b0, '0);
    endfunction

    function automatic void open_sector_erase();
        emit(OP_WREN, 1'b1, 1'b0, '0);
        emit(OP_SE4K, 1'b0, 1'b0, '0);
        emit_address(seq_addr, 1'b1);
    endfunction

    // pp frame stays open after the address, the data beats follow
    function automatic void open_page_chunk();
        logic [24:0] room;
        room = 25'(PAGE_BYTES) - 25'(seq_addr[PAGE_LOG-1:0]);
        seq_chunk_left = CHUNK_W'((room > seq_remaining) ? seq_remaining : room);
        emit(OP_WREN, 1'b1, 1'b0, '0);
        emit(OP_PP, 1'b0, 1'b0, '0);
        emit_address(seq_addr, 1'b0);
    endfunction

    // works out the spi beats caused by one accepted input beat
    function automatic void predict_spi_beats(input t_in_beat b);
        logic        idle;
        logic [24:0] step;
        t_out_beat   r;
        idle = (seq_mode != MODE_ERASE) && (seq_mode != MODE_PROG);
        burst_q.delete();
        if (b.cmd == CMD_RD_REQ && idle) begin
            emit(OP_WRDI, 1'b1, 1'b0, '0);
            emit(OP_READ, 1'b0, 1'b0, '0);
            emit(b.address[23:16], 1'b0, 1'b0, '0);
            emit(b.address[15:8], 1'b0, 1'b0, '0);
            emit(b.address[7:0], 1'b1, 1'b0, b.length);
        end else if (b.cmd == CMD_ERASE && idle && b.length != '0) begin
            seq_mode      = MODE_ERASE;
            seq_addr      = b.address;
            seq_remaining = b.length;
            open_sector_erase();
            emit(OP_RDSR1, 1'b1, 1'b1, '0);
            seq_wait_sr = 1'b1;
        end else if (b.cmd == CMD_PROG && idle && b.length != '0) begin
            seq_mode      = MODE_PROG;
            seq_addr      = b.address;
            seq_remaining = b.length;
            seq_wait_sr   = 1'b0;
            open_page_chunk();
        end else if (b.cmd == CMD_DATA && seq_mode == MODE_PROG && !seq_wait_sr &&
                     seq_chunk_left != '0) begin
            seq_chunk_left = seq_chunk_left - CHUNK_W'(1);
            seq_remaining  = seq_remaining - 25'd1;
            seq_addr       = seq_addr + 24'd1;
            if (seq_chunk_left == '0) begin
                emit(b.data_byte, 1'b1, 1'b0, '0);
                emit(OP_RDSR1, 1'b1, 1'b1, '0);
                seq_wait_sr = 1'b1;
            end else begin
                emit(b.data_byte, 1'b0, 1'b0, '0);
            end
        end else if (b.cmd == CMD_STATUS && seq_mode == MODE_ERASE && !seq_wait_sr) begin
            // next erase sector issued, any reply now starts its polling
            emit(OP_RDSR1, 1'b1, 1'b1, '0);
            seq_wait_sr = 1'b1;
        end else if (b.cmd == CMD_STATUS && seq_wait_sr && !idle) begin
            if ((b.data_byte & SR_BUSY) != '0) begin
                emit(OP_RDSR1, 1'b1, 1'b1, '0);
            end else begin
                seq_wait_sr = 1'b0;
                emit(OP_WRDI, 1'b1, 1'b0, '0);
                if (seq_mode == MODE_ERASE) begin
                    step = (seq_remaining > 25'(SECTOR_BYTES)) ? 25'(SECTOR_BYTES)
                                                               : seq_remaining;
                    seq_remaining = seq_remaining - step;
                    seq_addr      = seq_addr + 24'(SECTOR_BYTES);
                    if (seq_remaining != '0) open_sector_erase();
                    else seq_mode = MODE_IDLE;
                end else begin
                    if (seq_remaining != '0) open_page_chunk();
                    else seq_mode = MODE_IDLE;
                end
            end
        end
        if (burst_q.size() > 0) begin
            r = burst_q[burst_q.size() - 1];
            r.last = 1'b1;
            burst_q[burst_q.size() - 1] = r;
        end
        foreach (burst_q[i]) spi_bytes_due.push_back(burst_q[i]);
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [23:0] rand_address();
        return 24'($urandom());
    endfunction

    function automatic logic [24:0] rand_length();
        return 25'($urandom_range(0, 1 << 24));
    endfunction

    function automatic logic [7:0] busy_reply();
        return 8'($urandom()) | SR_BUSY;
    endfunction

    function automatic logic [7:0] clear_reply();
        return 8'($urandom()) & ~SR_BUSY;
    endfunction

    function automatic void queue_beat(input logic [2:0] c, input logic [23:0] a,
                                       input logic [24:0] len, input logic [7:0] d);
        t_in_beat b;
        b.cmd       = c;
        b.address   = a;
        b.length    = len;
        b.data_byte = d;
        requests_pending.push_back(b);
    endfunction

    // data and status beats carry random request fields, which the block ignores
    function automatic void queue_data(input logic [7:0] d);
        queue_beat(CMD_DATA, rand_address(), rand_length(), d);
    endfunction

    function automatic void queue_status(input logic [7:0] d);
        queue_beat(CMD_STATUS, rand_address(), rand_length(), d);
    endfunction

    function automatic logic noisy();
        return $urandom_range(0, 9) == 0;
    endfunction

    // a beat ignored while erase or program runs: a request, an unknown code, or the
    // given stray command
    function automatic void queue_busy_noise(input logic [2:0] stray);
        case ($urandom_range(0, 3))
            0, 1: queue_beat(3'($urandom_range(CMD_RD_REQ, CMD_PROG)), rand_address(),
                             rand_length(), 8'($urandom()));
            2: queue_beat(3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)),
                          rand_address(), rand_length(), 8'($urandom()));
            default: queue_beat(stray, rand_address(), rand_length(), 8'($urandom()));
        endcase
    endfunction

    // a beat ignored while idle
    function automatic void queue_idle_noise();
        case ($urandom_range(0, 3))
            0: queue_data(8'($urandom()));
            1: queue_status(8'($urandom()));
            2: queue_beat(3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)),
                          rand_address(), rand_length(), 8'($urandom()));
            default: queue_beat(3'($urandom_range(CMD_ERASE, CMD_PROG)), rand_address(),
                                '0, 8'($urandom()));
        endcase
    endfunction

    // whole program run: data per page chunk, then busy polls and a clear reply
    function automatic void queue_program_run();
        logic [23:0] a;
        int          len;
        int          left;
        int          room;
        int          chunk;
        a = rand_address();
        if ($urandom_range(0, 1) == 1) a[7:0] = 8'($urandom_range(232, 255));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        queue_beat(CMD_PROG, a, 25'(len), 8'($urandom()));
        left = len;
        while (left > 0) begin
            room  = PAGE_BYTES - int'(a[PAGE_LOG-1:0]);
            chunk = (room < left) ? room : left;
            repeat (chunk) begin
                if (noisy()) queue_busy_noise(CMD_STATUS);
                queue_data(8'($urandom()));
            end
            if (noisy()) queue_busy_noise(CMD_DATA);
            repeat ($urandom_range(0, 2)) queue_status(busy_reply());
            queue_status(clear_reply());
            left = left - chunk;
            a    = a + 24'(chunk);
        end
    endfunction

    // whole erase run: per sector a prompt reply (after the first), busy polls, clear
    function automatic void queue_erase_run();
        int len;
        int sectors;
        len     = $urandom_range(1, 3 * SECTOR_BYTES);
        sectors = (len + SECTOR_BYTES - 1) / SECTOR_BYTES;
        queue_beat(CMD_ERASE, rand_address(), 25'(len), 8'($urandom()));
        for (int s = 0; s < sectors; s++) begin
            if (s > 0) queue_status(8'($urandom()));
            if (noisy()) queue_busy_noise(CMD_DATA);
            repeat ($urandom_range(0, 3)) queue_status(busy_reply());
            queue_status(clear_reply());
        end
    endfunction

    function automatic void queue_directed();
        // empty read, then a read at the top address with a count of 0x1000000
        queue_beat(CMD_RD_REQ, 24'h000000, '0, 8'h00);
        queue_beat(CMD_RD_REQ, 24'hFFFFFF, 25'h1000000, 8'hFF);
        // empty erase and program, stray data and status, unknown codes
        queue_beat(CMD_ERASE, 24'h123456, '0, 8'h00);
        queue_beat(CMD_PROG, 24'h654321, '0, 8'h00);
        queue_data(8'hFF);
        queue_status(8'h00);
        for (int c = CMD_UNKNOWN_LO; c <= CMD_UNKNOWN_HI; c++)
            queue_beat(3'(c), rand_address(), rand_length(), 8'($urandom()));
        // two-sector erase wrapping past the top of the address space
        queue_beat(CMD_ERASE, 24'hFFF800, 25'd4097, 8'h00);
        queue_status(8'h01);
        queue_status(8'hFF);
        queue_status(8'h00);                          // continuation into the next sector
        queue_beat(CMD_RD_REQ, 24'hABCDEF, 25'd16, 8'h00);  // request while busy
        queue_status(8'hFE);                          // prompt, value does not matter
        queue_data(8'h5A);                            // stray data during erase
        queue_status(8'h02);
        // program across the wrap: a two-byte chunk, then one byte at address zero
        queue_beat(CMD_PROG, 24'hFFFFFE, 25'd3, 8'h00);
        queue_data(8'hFF);
        queue_beat(CMD_ERASE, 24'h000000, 25'd1, 8'h00);  // request while busy
        queue_data(8'h00);
        queue_data(8'h77);                            // stray data while polling
        queue_status(8'h01);
        queue_status(8'h00);
        queue_data(8'hA5);
        queue_status(8'hFE);
    endfunction

    function automatic void queue_random();
        while (requests_pending.size() < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1: queue_beat(CMD_RD_REQ, rand_address(), rand_length(), 8'($urandom()));
                2, 3, 4: queue_program_run();
                5, 6, 7: queue_erase_run();
                default: queue_idle_noise();
            endcase
        end
    endfunction

    // no idling of either side over the last few beats
    function automatic logic tail_calm();
        return random_loaded && requests_pending.size() < CALM_TAIL;
    endfunction

    // ---------------------------------------------------------------- driving

    // input side: a new beat only once the previous one has gone, plus idle bursts
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_took)) begin
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
                in_beat  <= requests_pending.pop_front();
                in_valid <= 1'b1;
                if (!tail_calm() && $urandom_range(0, 3) == 0) in_gap <= $urandom_range(1, 8);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side: ready with random stall bursts
    always @(negedge clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end else if (!tail_calm() && $urandom_range(0, 5) == 0) begin
            out_stall <= $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitoring

    // results are checked before the input beat of the same edge is predicted,
    // the queue keeps them in order either way
    always @(posedge clk) begin : spi_monitor
        t_out_beat want;
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (spi_bytes_due.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected spi beat: byte %02h frame_end %0b poll %0b rx %0d",
                                 out_beat.out_byte, out_beat.frame_end, out_beat.poll,
                                 out_beat.rx_count);
                    fail_count++;
                end else begin
                    want = spi_bytes_due.pop_front();
                    if (out_beat !== want) begin
                        if (fail_count < REPORT_MAX)
                            $display({"spi beat mismatch: byte %02h/%02h frame_end %0b/%0b ",
                                      "poll %0b/%0b rx %0d/%0d last %0b/%0b (exp/got)"},
                                     want.out_byte, out_beat.out_byte,
                                     want.frame_end, out_beat.frame_end,
                                     want.poll, out_beat.poll,
                                     want.rx_count, out_beat.rx_count,
                                     want.last, out_beat.last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) predict_spi_beats(in_beat);
            quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready))
                            ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog: the block has stopped moving beats
    always @(posedge clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("spi_nor_flash_command_sequencer_top test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        queue_directed();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // sender holds off until the directed part has fully drained
        do @(posedge clk);
        while (requests_pending.size() != 0 || in_valid || spi_bytes_due.size() != 0);
        queue_random();
        random_loaded = 1'b1;
        do @(posedge clk);
        while (requests_pending.size() != 0 || in_valid || spi_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("spi_nor_flash_command_sequencer_top test passed");
        end else begin
            $display("spi_nor_flash_command_sequencer_top test failed");
        end
        $finish;
    end

endmodule
